FILE: design/ispc_pkg.sv
// ----------------------------------------------------------------------------
// ispc_pkg: shared definitions for the interpolation search probe controller
// Widths, status and operation codes, register indexes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ispc_pkg;

	// Field widths.
	localparam int IDX_W      = 32;
	localparam int TIME_W     = 32;
	localparam int SPAN_W     = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = (TIME_W > SPAN_W) ? TIME_W : SPAN_W;

	// Reset value of the first-probe span.
	localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(10);

	// Interpolation arithmetic: magnitudes of the index and time differences,
	// their product, and the quotient bits that matter before clamping.
	localparam int MAG_A_W   = IDX_W + 1;
	localparam int MAG_T_W   = TIME_W + 1;
	localparam int PROD_W    = IDX_W + TIME_W + 1;
	localparam int QUO_W     = IDX_W + 2;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int WIDE_W    = IDX_W + 4;

	typedef enum logic [1:0] {
		ST_PROBE = 2'd0,
		ST_FOUND = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_PROBE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_TIME  = CFG_IDX_W'(0),
		CFG_INITIAL_SPAN = CFG_IDX_W'(1)
	} cfg_reg_t;

	// Outcome of the first evaluation of an accepted item.
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_RESULT = 2'd1,
		EV_INTERP = 2'd2
	} eval_kind_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic mul;
		logic div_start;
		logic fix;
		logic round;
		logic decide;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		eval_kind_t eval_kind;
		logic       div_busy;
	} dp_stat_t;

endpackage

FILE: design/ispc_div.sv
// ----------------------------------------------------------------------------
// ispc_div: iterative restoring divider
// Divides the interpolation product by the bracket time span, one quotient
// bit per cycle, and flags quotients too large for the index range.
// ----------------------------------------------------------------------------
module ispc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ispc_pkg::PROD_W-1:0]  dividend,
	input  logic [ispc_pkg::MAG_T_W-1:0] divisor,
	output logic                         busy,
	output logic                         ovf,
	output logic [ispc_pkg::QUO_W-1:0]   quotient,
	output logic [ispc_pkg::MAG_T_W-1:0] remainder
);
	import ispc_pkg::*;

	logic [PROD_W-QUO_W-1:0] top_part;
	logic                    ovf_now;
	logic [MAG_T_W:0]        trial;
	logic [MAG_T_W:0]        diff;
	logic                    take;
	logic [MAG_T_W-1:0]      rem_nx;

	logic                    busy_q;
	logic                    ovf_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [MAG_T_W-1:0]      rem_q;
	logic [QUO_W-1:0]        quo_q;

	// The quotient fits in QUO_W bits exactly when the bits above them are
	// below the divisor; that part also seeds the partial remainder.
	assign top_part = dividend[PROD_W-1:QUO_W];
	assign ovf_now  = MAG_T_W'(top_part) >= divisor;

	// One restoring step.
	assign trial  = {rem_q, quo_q[QUO_W-1]};
	assign take   = trial >= {1'b0, divisor};
	assign diff   = trial - {1'b0, divisor};
	assign rem_nx = take ? diff[MAG_T_W-1:0] : trial[MAG_T_W-1:0];

	// Step counter and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !ovf_now;
			ovf_q  <= ovf_now;
			cnt_q  <= CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Remainder and the shift register that turns dividend bits into quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= MAG_T_W'(top_part);
			quo_q <= dividend[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign busy      = busy_q;
	assign ovf       = ovf_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	// The partial remainder stays below the divisor through the whole division.
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < divisor)
		else $error("divider remainder reached the divisor");

	// A division runs for exactly one step per quotient bit.
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> ##DIV_STEPS !busy_q)
		else $error("divider ran for the wrong number of steps");

endmodule

FILE: design/ispc_dp.sv
// ----------------------------------------------------------------------------
// ispc_dp: datapath of the interpolation search probe controller
// Holds the configuration, the bracket points and the pending probe, does the
// exact interpolation with a multiplier and the iterative divider, and keeps
// the result and output registers.
// ----------------------------------------------------------------------------
module ispc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ispc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ispc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               operation,
	input  logic signed [ispc_pkg::IDX_W-1:0]  start_index,
	input  logic signed [ispc_pkg::TIME_W-1:0] probe_time,
	input  ispc_pkg::dp_cmd_t                  cmd,
	output ispc_pkg::dp_stat_t                 stat,
	output logic [1:0]                         status,
	output logic signed [ispc_pkg::IDX_W-1:0]  index_out,
	output logic signed [ispc_pkg::TIME_W-1:0] time_out
);
	import ispc_pkg::*;

	localparam logic signed [IDX_W-1:0] IDX_MAX = {1'b0, {(IDX_W-1){1'b1}}};
	localparam logic signed [IDX_W-1:0] IDX_MIN = {1'b1, {(IDX_W-1){1'b0}}};

	function automatic logic signed [WIDE_W-1:0] wide_idx(input logic signed [IDX_W-1:0] x);
		wide_idx = {{(WIDE_W-IDX_W){x[IDX_W-1]}}, x};
	endfunction

	function automatic logic signed [IDX_W-1:0] sat_idx(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi_lim;
		logic signed [WIDE_W-1:0] lo_lim;
		hi_lim = wide_idx(IDX_MAX);
		lo_lim = wide_idx(IDX_MIN);
		if (v > hi_lim) begin
			sat_idx = IDX_MAX;
		end else if (v < lo_lim) begin
			sat_idx = IDX_MIN;
		end else begin
			sat_idx = v[IDX_W-1:0];
		end
	endfunction

	// Configuration.
	logic signed [TIME_W-1:0] target_q;
	logic [SPAN_W-1:0]        span_q;

	// Captured item.
	op_t                      op_q;
	logic signed [IDX_W-1:0]  sidx_q;
	logic signed [TIME_W-1:0] ptime_q;

	// Search state.
	logic signed [IDX_W-1:0]  low_index_q;
	logic signed [IDX_W-1:0]  high_index_q;
	logic signed [TIME_W-1:0] low_time_q;
	logic signed [TIME_W-1:0] high_time_q;
	logic signed [IDX_W-1:0]  pending_q;
	logic                     store_high_q;
	logic                     active_q;

	// Interpolation registers.
	logic                     neg_q;
	logic [MAG_A_W-1:0]       mag_a_q;
	logic [MAG_T_W-1:0]       mag_b_q;
	logic [MAG_T_W-1:0]       mag_c_q;
	logic [PROD_W-1:0]        prod_q;
	logic signed [WIDE_W-1:0] w0_q;
	logic                     rgt_q;
	logic                     req_q;
	logic signed [IDX_W-1:0]  nl_q;

	// Result staging and output registers.
	status_t                  res_status_q;
	logic signed [IDX_W-1:0]  res_index_q;
	logic signed [TIME_W-1:0] res_time_q;
	status_t                  out_status_q;
	logic signed [IDX_W-1:0]  out_index_q;
	logic signed [TIME_W-1:0] out_time_q;

	// Evaluation signals.
	logic signed [TIME_W-1:0] lo_t_n;
	logic signed [TIME_W-1:0] hi_t_n;
	logic                     t_match;
	logic                     times_eq;
	logic signed [WIDE_W-1:0] span_w;
	logic signed [IDX_W-1:0]  start_low;
	logic [IDX_W:0]           dl;
	logic [TIME_W:0]          dt;
	logic [TIME_W:0]          dd;
	logic [MAG_A_W-1:0]       mag_a_n;
	logic [MAG_T_W-1:0]       mag_b_n;
	logic [MAG_T_W-1:0]       mag_c_n;
	logic                     neg_n;
	eval_kind_t               eval_kind;
	status_t                  ev_status;
	logic signed [IDX_W-1:0]  ev_index;
	logic signed [TIME_W-1:0] ev_time;

	// Multiply and divide.
	logic [MAG_A_W+MAG_T_W-1:0] prod_full;
	logic                       div_busy;
	logic                       div_ovf;
	logic [QUO_W-1:0]           div_quo;
	logic [MAG_T_W-1:0]         div_rem;

	// Quotient correction and rounding.
	logic                     rem_nz;
	logic [WIDE_W-1:0]        quo_ext;
	logic [WIDE_W-1:0]        q_plus;
	logic signed [WIDE_W-1:0] q_s;
	logic signed [WIDE_W-1:0] w0_n;
	logic [MAG_T_W:0]         rem2;
	logic [MAG_T_W:0]         c_ext;
	logic                     rgt_n;
	logic                     req_n;
	logic                     round_up;
	logic signed [WIDE_W-1:0] w_r;
	logic signed [IDX_W-1:0]  nl_n;

	// Bound decision.
	logic signed [WIDE_W-1:0] low_w;
	logic signed [WIDE_W-1:0] high_w;
	logic signed [WIDE_W-1:0] nl_w;
	logic signed [WIDE_W-1:0] span_hl;
	logic signed [WIDE_W-1:0] d_lo;
	logic signed [WIDE_W-1:0] d_hi;
	logic signed [WIDE_W-1:0] low_inc;
	logic signed [WIDE_W-1:0] high_dec;
	logic                     adjacent;
	logic                     closer_low;
	logic signed [IDX_W-1:0]  dec_low_index;
	logic signed [IDX_W-1:0]  dec_high_index;
	logic signed [TIME_W-1:0] dec_low_time;
	logic signed [TIME_W-1:0] dec_high_time;
	logic                     dec_store_high;
	logic                     dec_active;
	status_t                  dec_status;
	logic signed [IDX_W-1:0]  dec_index;
	logic signed [TIME_W-1:0] dec_time;

	// First look at the captured item: bracket times after storing the probe
	// time, the match checks, and the signed differences for interpolation.
	assign lo_t_n    = store_high_q ? low_time_q : ptime_q;
	assign hi_t_n    = store_high_q ? ptime_q : high_time_q;
	assign t_match   = ptime_q == target_q;
	assign times_eq  = hi_t_n == lo_t_n;
	assign span_w    = {{(WIDE_W-SPAN_W){1'b0}}, span_q};
	assign start_low = sat_idx(wide_idx(sidx_q) - span_w);

	assign dl      = {high_index_q[IDX_W-1], high_index_q} - {low_index_q[IDX_W-1], low_index_q};
	assign dt      = {target_q[TIME_W-1], target_q} - {lo_t_n[TIME_W-1], lo_t_n};
	assign dd      = {hi_t_n[TIME_W-1], hi_t_n} - {lo_t_n[TIME_W-1], lo_t_n};
	assign mag_a_n = dl[IDX_W] ? (~dl + MAG_A_W'(1)) : dl;
	assign mag_b_n = dt[TIME_W] ? (~dt + MAG_T_W'(1)) : dt;
	assign mag_c_n = dd[TIME_W] ? (~dd + MAG_T_W'(1)) : dd;
	assign neg_n   = dl[IDX_W] ^ dt[TIME_W] ^ dd[TIME_W];

	always_comb begin
		eval_kind = EV_INTERP;
		ev_status = ST_ERROR;
		ev_index  = '0;
		ev_time   = '0;
		if (op_q == OP_START) begin
			eval_kind = EV_RESULT;
			if (t_match) begin
				ev_status = ST_FOUND;
				ev_index  = sidx_q;
				ev_time   = ptime_q;
			end else begin
				ev_status = ST_PROBE;
				ev_index  = start_low;
			end
		end else if (!active_q) begin
			eval_kind = EV_NONE;
		end else if (t_match) begin
			eval_kind = EV_RESULT;
			ev_status = ST_FOUND;
			ev_index  = pending_q;
			ev_time   = ptime_q;
		end else if (times_eq) begin
			eval_kind = EV_RESULT;
		end
	end

	// Product of the index and time distances.
	assign prod_full = mag_a_q * mag_b_q;

	ispc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (prod_q),
		.divisor   (mag_c_q),
		.busy      (div_busy),
		.ovf       (div_ovf),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Floor quotient and offset from the low bound. For a negative ratio the
	// floor is one below the truncated value when there is a remainder, and
	// the rounding remainder becomes divisor minus remainder.
	assign rem_nz  = div_rem != '0;
	assign quo_ext = WIDE_W'(div_quo);
	assign q_plus  = quo_ext + WIDE_W'(rem_nz);
	assign q_s     = neg_q ? (WIDE_W'(0) - q_plus) : quo_ext;
	assign w0_n    = wide_idx(low_index_q) + q_s;
	assign rem2    = {div_rem, 1'b0};
	assign c_ext   = {1'b0, mag_c_q};
	assign rgt_n   = neg_q ? (rem_nz && (rem2 < c_ext)) : (rem2 > c_ext);
	assign req_n   = rem2 == c_ext;

	// Round half away from zero and clamp to the index range.
	assign round_up = rgt_q | (req_q & ~w0_q[WIDE_W-1]);
	assign w_r      = w0_q + $signed(WIDE_W'(round_up));
	assign nl_n     = div_ovf ? (neg_q ? IDX_MIN : IDX_MAX) : sat_idx(w_r);

	// Place the new index against the bracket.
	assign low_w      = wide_idx(low_index_q);
	assign high_w     = wide_idx(high_index_q);
	assign nl_w       = wide_idx(nl_q);
	assign span_hl    = high_w - low_w;
	assign adjacent   = span_hl == $signed(WIDE_W'(1));
	assign d_lo       = nl_w - low_w;
	assign d_hi       = high_w - nl_w;
	assign closer_low = d_lo <= d_hi;
	assign low_inc    = low_w + $signed(WIDE_W'(1));
	assign high_dec   = high_w - $signed(WIDE_W'(1));

	always_comb begin
		dec_low_index  = low_index_q;
		dec_high_index = high_index_q;
		dec_low_time   = low_time_q;
		dec_high_time  = high_time_q;
		dec_store_high = store_high_q;
		dec_active     = active_q;
		dec_status     = ST_PROBE;
		dec_index      = nl_q;
		dec_time       = '0;
		priority if (nl_q < low_index_q) begin
			// Extrapolated below: the old low bound becomes the high bound.
			dec_high_index = low_index_q;
			dec_high_time  = low_time_q;
			dec_low_index  = nl_q;
			dec_store_high = 1'b0;
		end else if (nl_q > high_index_q) begin
			// Extrapolated above: the old high bound becomes the low bound.
			dec_low_index  = high_index_q;
			dec_low_time   = high_time_q;
			dec_high_index = nl_q;
			dec_store_high = 1'b1;
		end else if (nl_q == low_index_q) begin
			if (adjacent) begin
				dec_status = ST_FOUND;
				dec_index  = low_index_q;
				dec_time   = low_time_q;
				dec_active = 1'b0;
			end else begin
				dec_index      = sat_idx(low_inc);
				dec_high_index = sat_idx(low_inc);
				dec_store_high = 1'b1;
			end
		end else if (nl_q == high_index_q) begin
			if (adjacent) begin
				dec_status = ST_FOUND;
				dec_index  = high_index_q;
				dec_time   = high_time_q;
				dec_active = 1'b0;
			end else begin
				dec_index      = sat_idx(high_dec);
				dec_low_index  = sat_idx(high_dec);
				dec_store_high = 1'b0;
			end
		end else if (closer_low) begin
			// Inside the bracket: the new point replaces the farther bound.
			dec_high_index = nl_q;
			dec_store_high = 1'b1;
		end else begin
			dec_low_index  = nl_q;
			dec_store_high = 1'b0;
		end
	end

	// Configuration and search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			span_q       <= SPAN_RESET;
			low_index_q  <= '0;
			high_index_q <= '0;
			low_time_q   <= '0;
			high_time_q  <= '0;
			pending_q    <= '0;
			store_high_q <= 1'b0;
			active_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_TARGET_TIME: begin
						target_q <= cfg_data[TIME_W-1:0];
					end
					CFG_INITIAL_SPAN: begin
						span_q <= cfg_data[SPAN_W-1:0];
					end
				endcase
			end
			if (cmd.eval) begin
				if (op_q == OP_START) begin
					high_index_q <= sidx_q;
					high_time_q  <= ptime_q;
					if (t_match) begin
						active_q <= 1'b0;
					end else begin
						low_index_q  <= start_low;
						pending_q    <= start_low;
						store_high_q <= 1'b0;
						active_q     <= 1'b1;
					end
				end else if (active_q) begin
					low_time_q  <= lo_t_n;
					high_time_q <= hi_t_n;
					if (t_match || times_eq) begin
						active_q <= 1'b0;
					end
				end
			end
			if (cmd.decide) begin
				low_index_q  <= dec_low_index;
				high_index_q <= dec_high_index;
				low_time_q   <= dec_low_time;
				high_time_q  <= dec_high_time;
				store_high_q <= dec_store_high;
				active_q     <= dec_active;
				if (dec_status == ST_PROBE) begin
					pending_q <= dec_index;
				end
			end
		end
	end

	// Item capture, interpolation pipeline and result registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(operation);
			sidx_q  <= start_index;
			ptime_q <= probe_time;
		end
		if (cmd.eval) begin
			neg_q   <= neg_n;
			mag_a_q <= mag_a_n;
			mag_b_q <= mag_b_n;
			mag_c_q <= mag_c_n;
			if (eval_kind == EV_RESULT) begin
				res_status_q <= ev_status;
				res_index_q  <= ev_index;
				res_time_q   <= ev_time;
			end
		end
		if (cmd.mul) begin
			prod_q <= prod_full[PROD_W-1:0];
		end
		if (cmd.fix) begin
			w0_q  <= w0_n;
			rgt_q <= rgt_n;
			req_q <= req_n;
		end
		if (cmd.round) begin
			nl_q <= nl_n;
		end
		if (cmd.decide) begin
			res_status_q <= dec_status;
			res_index_q  <= dec_index;
			res_time_q   <= dec_time;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_time_q   <= res_time_q;
		end
	end

	assign stat.eval_kind = eval_kind;
	assign stat.div_busy  = div_busy;

	assign status    = out_status_q;
	assign index_out = out_index_q;
	assign time_out  = out_time_q;

	// The bound decision always ends in a probe or an answer, never an error.
	a_decide_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> res_status_q != ST_ERROR)
		else $error("bound decision produced an error status");

endmodule

FILE: design/ispc_ctrl.sv
// ----------------------------------------------------------------------------
// ispc_ctrl: sequencer of the interpolation search probe controller
// Accepts one item at a time, steps the datapath through evaluation,
// multiplication, division, rounding and the bound decision, and hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module ispc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ispc_pkg::dp_cmd_t  cmd,
	input  ispc_pkg::dp_stat_t stat
);
	import ispc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_DIV_START,
		S_DIV,
		S_FIX,
		S_ROUND,
		S_DECIDE,
		S_DELIVER
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// Datapath commands follow the state; the output register loads only
	// when it is empty or its transaction completes in the same cycle.
	always_comb begin
		cmd           = '0;
		cmd.capture   = in_valid && (state_q == S_IDLE);
		cmd.eval      = state_q == S_EVAL;
		cmd.mul       = state_q == S_MUL;
		cmd.div_start = state_q == S_DIV_START;
		cmd.fix       = state_q == S_FIX;
		cmd.round     = state_q == S_ROUND;
		cmd.decide    = state_q == S_DECIDE;
		cmd.load_out  = (state_q == S_DELIVER) && (!out_valid_q || out_ready);
	end

	// State register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					unique case (stat.eval_kind)
						EV_RESULT: state_q <= S_DELIVER;
						EV_INTERP: state_q <= S_MUL;
						default:   state_q <= S_IDLE;
					endcase
				end
				S_MUL: begin
					state_q <= S_DIV_START;
				end
				S_DIV_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!stat.div_busy) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_DELIVER;
				end
				S_DELIVER: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A probe that arrives with no search running produces no transaction.
	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) && (stat.eval_kind == EV_NONE)
		|=> (state_q == S_IDLE) && !$rose(out_valid_q))
		else $error("idle probe produced a result");

	// A new result appears only from the delivery step.
	a_result_from_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DELIVER)
		else $error("output valid rose outside delivery");

	// No item is taken while the divider is working.
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !in_ready)
		else $error("input ready during a division");

endmodule

FILE: design/interpolation_search_probe_controller.sv
// ----------------------------------------------------------------------------
// interpolation_search_probe_controller: top level
// Interpolation search over a rising index-to-time table, one probe at a time.
// ----------------------------------------------------------------------------
// Usage:
// Write target_time (index 0) and initial_span (index 1) on the cfg port
// while the block is idle. A start transaction (operation 0) carries the
// newest index and its time; the block answers with either the found index
// or the first index to probe. Each probe-result transaction (operation 1)
// carries the time read at the index last requested and is answered with the
// next index to probe, the answer, or an error when the bracket times match.
// A probe transaction with no search running is taken and gives no result.
// A start item, and a probe item that matches the target or finds equal
// bracket times, go from evaluation straight to delivery. A probe item that
// interpolates passes the multiplier, the restoring divider, rounding and
// the bound decision; the divider produces one quotient bit per cycle in 34
// steps, or skips its steps when the quotient is too large for the index
// range. The block takes its next item in the cycle after handing a result
// to the output register, so it accepts while a result still waits to be
// taken. When the receiver stalls, a finished result waits in the delivery
// step until the output register frees up. Reset clears the search state,
// sets target_time to 0 and initial_span to 10, and leaves the outputs empty.
// ----------------------------------------------------------------------------
module interpolation_search_probe_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ispc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ispc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               operation,
	input  logic signed [ispc_pkg::IDX_W-1:0]  start_index,
	input  logic signed [ispc_pkg::TIME_W-1:0] probe_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic signed [ispc_pkg::IDX_W-1:0]  index_out,
	output logic signed [ispc_pkg::TIME_W-1:0] time_out
);
	import ispc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	ispc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Arithmetic, search state and output registers.
	ispc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.start_index (start_index),
		.probe_time  (probe_time),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.index_out   (index_out),
		.time_out    (time_out)
	);

endmodule
